/* design/pgw_pkg.sv */
// Shared types, constants and helpers for the four-level page table walker.
// No dependencies; used by every module of the walker except pgw_ram.
package pgw_pkg;

   localparam int TABLE_PAGES_DEFAULT = 16;
   localparam int ENTRIES_PER_TABLE   = 512;
   localparam int SLICE_W             = 9;
   localparam int OFFSET_W            = 12;
   localparam int VA_W                = 48;
   localparam int PA_W                = 52;
   localparam int FRAME_W             = PA_W - OFFSET_W;
   localparam int ENTRY_W             = 64;
   localparam int CSR_DATA_W          = 64;
   localparam int CSR_ADDR_W          = 4;

   localparam logic [OFFSET_W-1:0] FLAG_PRESENT = 12'h001;
   localparam logic [OFFSET_W-1:0] FLAG_WRITE   = 12'h002;
   localparam logic [1:0]          LAST_LEVEL   = 2'd3;
   localparam logic                CSR_POOL_BASE = 1'b0;

   typedef enum logic [1:0] {
      REQ_MAP       = 2'd0,
      REQ_UNMAP     = 2'd1,
      REQ_TRANSLATE = 2'd2
   } req_code_type;

   typedef enum logic [1:0] {
      STATUS_DONE        = 2'd0,
      STATUS_NOT_MAPPED  = 2'd1,
      STATUS_POOL_EMPTY  = 2'd2,
      STATUS_OUTSIDE     = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_CHECK,
      ST_PUSH
   } state_type;

   typedef enum logic {
      ADDR_OP_LINK,
      ADDR_OP_DECODE
   } addr_op_type;

   typedef struct packed {
      addr_op_type          op;
      logic [FRAME_W-1:0]   operand;
   } addr_cmd_type;

   typedef struct packed {
      logic [FRAME_W-1:0]   sum;
      logic                 out_of_pool;
   } addr_res_type;

   function automatic logic [SLICE_W-1:0] va_slice(input logic [VA_W-1:0] va,
                                                   input logic [1:0] level);
      logic [SLICE_W-1:0] s;
      unique case (level)
         2'd0: s = va[47:39];
         2'd1: s = va[38:30];
         2'd2: s = va[29:21];
         default: s = va[20:12];
      endcase
      return s;
   endfunction

endpackage

/* design/pgw_ram.sv */
// Generic single-port RAM with a registered read port.
// No dependencies.
module pgw_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* design/pgw_addr_unit.sv */
// Shared pool address adder: builds table links and decodes them back to pages.
// Depends on pgw_pkg.
module pgw_addr_unit #(
   parameter int TABLE_PAGES = pgw_pkg::TABLE_PAGES_DEFAULT
) (
   input  logic [pgw_pkg::FRAME_W-1:0] base_frame,
   input  pgw_pkg::addr_cmd_type       cmd,
   output pgw_pkg::addr_res_type       res
);
   import pgw_pkg::*;

   logic [FRAME_W-1:0] sum;

   always_comb begin
      unique case (cmd.op)
         ADDR_OP_LINK:   sum = base_frame + cmd.operand;
         ADDR_OP_DECODE: sum = cmd.operand - base_frame;
         default:        sum = '0;
      endcase
      res.sum         = sum;
      res.out_of_pool = (sum >= FRAME_W'(TABLE_PAGES));
   end

endmodule

/* design/pgw_seq.sv */
// Walk sequencer: clearing pass, four-level walk, allocation and result register.
// Depends on pgw_pkg; drives the table RAM and the shared address unit.
module pgw_seq #(
   parameter int TABLE_PAGES = pgw_pkg::TABLE_PAGES_DEFAULT,
   parameter int PAGE_W      = $clog2(TABLE_PAGES),
   parameter int ADDR_W      = PAGE_W + pgw_pkg::SLICE_W
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          rebuild,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_type,
   input  logic [pgw_pkg::VA_W-1:0]      req_virt_addr,
   input  logic [pgw_pkg::PA_W-1:0]      req_phys_frame,
   input  logic [pgw_pkg::OFFSET_W-1:0]  req_entry_flags,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [pgw_pkg::PA_W-1:0]      rsp_phys_addr,
   output logic                          rsp_hit,
   output logic [1:0]                    rsp_status,
   output logic                          ram_we,
   output logic                          ram_re,
   output logic [ADDR_W-1:0]             ram_addr,
   output logic [pgw_pkg::ENTRY_W-1:0]   ram_wdata,
   input  logic [pgw_pkg::ENTRY_W-1:0]   ram_rdata,
   output pgw_pkg::addr_cmd_type         addr_cmd,
   input  pgw_pkg::addr_res_type         addr_res
);
   import pgw_pkg::*;

   localparam int CNT_W = $clog2(TABLE_PAGES + 1);
   localparam int DEPTH = TABLE_PAGES * ENTRIES_PER_TABLE;

   state_type            state_ff, state_in;
   logic [1:0]           level_ff, level_in;
   logic [PAGE_W-1:0]    page_ff, page_in;
   logic [CNT_W-1:0]     nfp_ff, nfp_in;
   logic [ADDR_W-1:0]    clr_ff, clr_in;
   logic [1:0]           type_ff, type_in;
   logic [VA_W-1:0]      va_ff, va_in;
   logic [FRAME_W-1:0]   frame_ff, frame_in;
   logic [OFFSET_W-1:0]  flags_ff, flags_in;
   logic [PA_W-1:0]      res_phys_ff, res_phys_in;
   logic                 res_hit_ff, res_hit_in;
   status_type           res_status_ff, res_status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [PA_W-1:0]      rsp_phys_ff, rsp_phys_in;
   logic                 rsp_hit_ff, rsp_hit_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;
   logic                 present;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         level_ff     <= '0;
         page_ff      <= '0;
         nfp_ff       <= CNT_W'(2);
         clr_ff       <= ADDR_W'(DEPTH - 1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         level_ff     <= level_in;
         page_ff      <= page_in;
         nfp_ff       <= nfp_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff       <= type_in;
      va_ff         <= va_in;
      frame_ff      <= frame_in;
      flags_ff      <= flags_in;
      res_phys_ff   <= res_phys_in;
      res_hit_ff    <= res_hit_in;
      res_status_ff <= res_status_in;
      rsp_phys_ff   <= rsp_phys_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign present = ram_rdata[0];

   always_comb begin
      state_in      = state_ff;
      level_in      = level_ff;
      page_in       = page_ff;
      nfp_in        = nfp_ff;
      clr_in        = clr_ff;
      type_in       = type_ff;
      va_in         = va_ff;
      frame_in      = frame_ff;
      flags_in      = flags_ff;
      res_phys_in   = res_phys_ff;
      res_hit_in    = res_hit_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_phys_in   = rsp_phys_ff;
      rsp_hit_in    = rsp_hit_ff;
      rsp_status_in = rsp_status_ff;
      req_ready     = 1'b0;
      ram_we        = 1'b0;
      ram_re        = 1'b0;
      ram_addr      = {page_ff, va_slice(va_ff, level_ff)};
      ram_wdata     = '0;
      addr_cmd.op      = ADDR_OP_DECODE;
      addr_cmd.operand = ram_rdata[PA_W-1:OFFSET_W];

      unique case (state_ff)
         ST_CLEAR: begin
            ram_we           = 1'b1;
            ram_addr         = clr_ff;
            addr_cmd.op      = ADDR_OP_LINK;
            addr_cmd.operand = FRAME_W'(1);
            if (clr_ff == '0) begin
               ram_wdata = {12'b0, addr_res.sum, FLAG_PRESENT | FLAG_WRITE};
               state_in  = ST_IDLE;
            end
            clr_in = clr_ff - ADDR_W'(1);
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               type_in       = req_type;
               va_in         = req_virt_addr;
               frame_in      = req_phys_frame[PA_W-1:OFFSET_W];
               flags_in      = req_entry_flags;
               level_in      = '0;
               page_in       = '0;
               res_phys_in   = '0;
               res_hit_in    = 1'b0;
               res_status_in = STATUS_DONE;
               if (req_type == REQ_MAP || req_type == REQ_UNMAP ||
                   req_type == REQ_TRANSLATE) begin
                  state_in = ST_READ;
               end else begin
                  state_in = ST_PUSH;
               end
            end
         end
         ST_READ: begin
            ram_re   = 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = ST_PUSH;
            if (level_ff != LAST_LEVEL) begin
               if (!present) begin
                  if (type_ff != REQ_MAP) begin
                     res_status_in = STATUS_NOT_MAPPED;
                  end else if (nfp_ff >= CNT_W'(TABLE_PAGES)) begin
                     res_status_in = STATUS_POOL_EMPTY;
                  end else begin
                     addr_cmd.op      = ADDR_OP_LINK;
                     addr_cmd.operand = FRAME_W'(nfp_ff);
                     ram_we    = 1'b1;
                     ram_wdata = {12'b0, addr_res.sum, FLAG_PRESENT | FLAG_WRITE};
                     nfp_in    = nfp_ff + CNT_W'(1);
                     page_in   = nfp_ff[PAGE_W-1:0];
                     level_in  = level_ff + 2'd1;
                     state_in  = ST_READ;
                  end
               end else if (addr_res.out_of_pool) begin
                  res_status_in = STATUS_OUTSIDE;
               end else begin
                  page_in  = addr_res.sum[PAGE_W-1:0];
                  level_in = level_ff + 2'd1;
                  state_in = ST_READ;
               end
            end else begin
               unique case (type_ff)
                  REQ_MAP: begin
                     ram_we    = 1'b1;
                     ram_wdata = {12'b0, frame_ff, flags_ff | FLAG_PRESENT};
                  end
                  REQ_UNMAP: begin
                     ram_we = 1'b1;
                     if (!present) begin
                        res_status_in = STATUS_NOT_MAPPED;
                     end
                  end
                  REQ_TRANSLATE: begin
                     if (present) begin
                        res_phys_in = {ram_rdata[PA_W-1:OFFSET_W], va_ff[OFFSET_W-1:0]};
                        res_hit_in  = 1'b1;
                     end else begin
                        res_status_in = STATUS_NOT_MAPPED;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_PUSH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_phys_in   = res_phys_ff;
               rsp_hit_in    = res_hit_ff;
               rsp_status_in = res_status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase

      if (rebuild) begin
         state_in = ST_CLEAR;
         clr_in   = ADDR_W'(DEPTH - 1);
         nfp_in   = CNT_W'(2);
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_phys_addr = rsp_phys_ff;
   assign rsp_hit       = rsp_hit_ff;
   assign rsp_status    = rsp_status_ff;

   a_pool_bound: assert property (@(posedge clock) disable iff (reset)
      nfp_ff <= CNT_W'(TABLE_PAGES))
      else $error("Free page counter ran past the pool.");

   a_pool_step: assert property (@(posedge clock) disable iff (reset)
      (nfp_ff != $past(nfp_ff)) |->
         (nfp_ff == $past(nfp_ff) + CNT_W'(1)) || (nfp_ff == CNT_W'(2)))
      else $error("Free page counter moved by more than one page.");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !rebuild) |=> !req_ready)
      else $error("A second request was taken while a walk was in flight.");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !$past(rsp_valid && !rsp_ready)) |-> ($past(state_ff) == ST_PUSH))
      else $error("A result transfer appeared outside the push step.");

endmodule

/* design/four_level_page_table_walker.sv */
// Top level of the four-level page table walker: CSR port, table RAM,
// address unit and walk sequencer. Depends on pgw_pkg, pgw_ram, pgw_addr_unit, pgw_seq.
//
//  Channel   Ports                                   Direction   Handshake
//  request   req_type/virt_addr/phys_frame/flags     in          req_valid / req_ready
//  result    rsp_phys_addr/hit/status                out         rsp_valid / rsp_ready
//  csr       psel/penable/pwrite/paddr/pwdata/prdata in/out      APB, pready tied high
//
// A request reads one table entry per level through the single RAM port, with a read state
// and a check state per level for its registered read, then hands the result to the output
// register in the push state and returns to idle; an early miss or fault ends the walk sooner.
// After reset and after every pool_base write, a clearing pass over all TABLE_PAGES * 512
// entries sweeps the RAM and rebuilds the root table; req_ready stays low during the pass.
// A finished result waits in the output register while the next request is taken.
module four_level_page_table_walker #(
   parameter int TABLE_PAGES = pgw_pkg::TABLE_PAGES_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [1:0]                       req_type,
   input  logic [pgw_pkg::VA_W-1:0]         req_virt_addr,
   input  logic [pgw_pkg::PA_W-1:0]         req_phys_frame,
   input  logic [pgw_pkg::OFFSET_W-1:0]     req_entry_flags,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [pgw_pkg::PA_W-1:0]         rsp_phys_addr,
   output logic                             rsp_hit,
   output logic [1:0]                       rsp_status,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [pgw_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [pgw_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [pgw_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready
);
   import pgw_pkg::*;

   localparam int PAGE_W = $clog2(TABLE_PAGES);
   localparam int ADDR_W = PAGE_W + SLICE_W;
   localparam int DEPTH  = TABLE_PAGES * ENTRIES_PER_TABLE;

   logic [PA_W-1:0]    base_ff, base_in;
   logic               base_wr;
   logic               ram_we;
   logic               ram_re;
   logic [ADDR_W-1:0]  ram_addr;
   logic [ENTRY_W-1:0] ram_wdata;
   logic [ENTRY_W-1:0] ram_rdata;
   addr_cmd_type       addr_cmd;
   addr_res_type       addr_res;

   assign pready  = 1'b1;
   assign base_wr = psel && penable && pwrite && pready && (paddr[3] == CSR_POOL_BASE);
   assign base_in = base_wr ? pwdata[PA_W-1:0] : base_ff;
   assign prdata  = (paddr[3] == CSR_POOL_BASE) ? {12'b0, base_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
      end else begin
         base_ff <= base_in;
      end
   end

   pgw_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_table_ram (
      .clock (clock),
      .we    (ram_we),
      .re    (ram_re),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   pgw_addr_unit #(
      .TABLE_PAGES (TABLE_PAGES)
   ) u_addr_unit (
      .base_frame (base_ff[PA_W-1:OFFSET_W]),
      .cmd        (addr_cmd),
      .res        (addr_res)
   );

   pgw_seq #(
      .TABLE_PAGES (TABLE_PAGES),
      .PAGE_W      (PAGE_W),
      .ADDR_W      (ADDR_W)
   ) u_seq (
      .clock           (clock),
      .reset           (reset),
      .rebuild         (base_wr),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_virt_addr   (req_virt_addr),
      .req_phys_frame  (req_phys_frame),
      .req_entry_flags (req_entry_flags),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_phys_addr   (rsp_phys_addr),
      .rsp_hit         (rsp_hit),
      .rsp_status      (rsp_status),
      .ram_we          (ram_we),
      .ram_re          (ram_re),
      .ram_addr        (ram_addr),
      .ram_wdata       (ram_wdata),
      .ram_rdata       (ram_rdata),
      .addr_cmd        (addr_cmd),
      .addr_res        (addr_res)
   );

endmodule
